/* src/sos_pkg.sv */
// Shared types, constants and helpers for the sparse octree store.
package sos_pkg;

    localparam int BRANCH_COUNT_DEF = 1024;
    localparam int MAX_DEPTH_DEF    = 6;
    localparam int VALUE_BITS_DEF   = 32;

    localparam int KEY_W       = 21;
    localparam int FIELD_VAL_W = 32;
    localparam int LEVEL_W     = 3;
    localparam int CHILD_W     = 3;
    localparam int KEY_EXT_W   = CHILD_W * 8;
    localparam int CFG_W       = 3;
    localparam int S_TDATA_W   = 56;
    localparam int M_TDATA_W   = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] DEPTH_RESET = 3'd6;

    localparam logic MODE_READ    = 1'b0;
    localparam logic MODE_WRITE   = 1'b1;
    localparam logic STATUS_DONE  = 1'b0;
    localparam logic STATUS_FULL  = 1'b1;

    // One classified request as it waits between front and back.
    typedef struct packed {
        logic                   mode;
        logic [KEY_W-1:0]       key;
        logic [FIELD_VAL_W-1:0] value;
        logic [LEVEL_W-1:0]     level;
    } sos_req_t;

    typedef struct packed {
        logic full;
        logic valid;
    } sos_qstat_t;

    // Child index for a level; levels above the key width select child zero.
    function automatic logic [CHILD_W-1:0] child_of(logic [KEY_W-1:0] key,
                                                    logic [LEVEL_W-1:0] level);
        logic [KEY_EXT_W-1:0] key_ext;
        logic [4:0]           shamt;
        key_ext  = KEY_EXT_W'(key);
        shamt    = 5'(level) * 5'd3;
        child_of = CHILD_W'(key_ext >> shamt);
    endfunction

endpackage

/* src/sos_front.sv */
// Front end: accepts requests, holds the depth register and classifies the root level.
module sos_front #(
    parameter int MAX_DEPTH = sos_pkg::MAX_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sos_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sos_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  sos_pkg::sos_qstat_t             q_stat,
    input  logic                            clearing,
    output logic                            q_push,
    output sos_pkg::sos_req_t               q_req
);
    import sos_pkg::*;

    localparam logic [LEVEL_W-1:0] DEPTH_CAP = LEVEL_W'(MAX_DEPTH);

    logic [CFG_W-1:0]   depth_reg;
    logic [CFG_W-1:0]   depth_next;
    logic [LEVEL_W-1:0] root_level;

    assign cfg_ready  = 1'b1;
    assign depth_next = cfg_valid ? cfg_data : depth_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= DEPTH_RESET;
        end else begin
            depth_reg <= depth_next;
        end
    end

    // Clamp an oversized depth to the deepest supported level.
    assign root_level = (depth_reg > DEPTH_CAP) ? DEPTH_CAP : depth_reg;

    assign s_tready = !q_stat.full && !clearing;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        q_req.mode  = s_tuser;
        q_req.key   = s_tdata[KEY_W-1:0];
        q_req.value = s_tdata[KEY_W +: FIELD_VAL_W];
        q_req.level = root_level;
    end

endmodule

/* src/sos_queue.sv */
// Short request queue between front end and tree engine.
module sos_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  sos_pkg::sos_req_t   push_req,
    input  logic                pop,
    output sos_pkg::sos_req_t   head_req,
    output sos_pkg::sos_qstat_t stat
);
    import sos_pkg::*;

    sos_req_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    assign head_req   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.valid = (count_reg != '0);

endmodule

/* src/sos_back.sv */
// Tree engine: walks and grows the octree in the branch pool and returns results.
module sos_back #(
    parameter int BRANCH_COUNT = sos_pkg::BRANCH_COUNT_DEF,
    parameter int VALUE_BITS   = sos_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sos_pkg::sos_qstat_t             q_stat,
    input  sos_pkg::sos_req_t               q_req,
    output logic                            q_pop,
    output logic                            clearing,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sos_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser
);
    import sos_pkg::*;

    localparam int BIW   = $clog2(BRANCH_COUNT);
    localparam int SLOTS = BRANCH_COUNT * 8;
    localparam int SAW   = BIW + CHILD_W;
    localparam int NFW   = $clog2(BRANCH_COUNT + 1);
    localparam int DW    = VALUE_BITS + NFW;
    localparam int PW    = VALUE_BITS + 32;
    localparam int STW   = 2;

    // Scaled reciprocal of the pool size; the quotient estimate is at most one low.
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BRANCH_COUNT);

    localparam logic [STW-1:0] MOD_RECIP = 2'd2;
    localparam logic [STW-1:0] MOD_SUB   = 2'd1;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_ISSUE = 9'b000000100,
        ST_WALK  = 9'b000001000,
        ST_MOD   = 9'b000010000,
        ST_ALLOC = 9'b000100000,
        ST_AREAD = 9'b001000000,
        ST_LEAF  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SAW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [NFW-1:0]         nf_reg, nf_next;
    logic [BIW-1:0]         branch_reg, branch_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic                   mode_reg, mode_next;
    logic [VALUE_BITS-1:0]  wval_reg, wval_next;
    logic [VALUE_BITS-1:0]  res_value_reg, res_value_next;
    logic                   res_status_reg, res_status_next;
    logic [DW-1:0]          rem_reg, rem_next;
    logic [DW-1:0]          div_reg, div_next;
    logic [STW-1:0]         step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]  out_value_reg, out_value_next;
    logic                   out_status_reg, out_status_next;

    logic [7:0]             flags_mem [BRANCH_COUNT];
    logic [VALUE_BITS-1:0]  slot_mem  [SLOTS];
    logic [7:0]             flags_q;
    logic [VALUE_BITS-1:0]  slot_q;

    logic [BIW-1:0]         rd_branch;
    logic [CHILD_W-1:0]     rd_child;
    logic                   flags_we;
    logic [BIW-1:0]         flags_waddr;
    logic [7:0]             flags_wdata;
    logic                   slot_we;
    logic [SAW-1:0]         slot_waddr;
    logic [VALUE_BITS-1:0]  slot_wdata;

    logic [CHILD_W-1:0]     child_cur;
    logic [LEVEL_W-1:0]     level_dn;
    logic [CHILD_W-1:0]     child_dn;
    logic                   flag_hit;
    logic                   ptr_in_range;
    logic                   pool_short;
    logic [NFW:0]           nf_need;
    logic [VALUE_BITS-1:0]  alloc_val;
    logic [PW-1:0]          recip_prod;
    logic [DW-1:0]          qd_prod;
    logic [DW-1:0]          rem_fix;

    assign child_cur    = child_of(key_reg, level_reg);
    assign level_dn     = level_reg - 1'b1;
    assign child_dn     = child_of(key_reg, level_dn);
    assign flag_hit     = (level_reg != '0) && flags_q[child_cur];
    assign ptr_in_range = DW'(slot_q) < DW'(BRANCH_COUNT);
    assign nf_need      = (NFW + 1)'(nf_reg) + (NFW + 1)'(level_reg);
    assign pool_short   = (level_reg != '0) && (nf_need > (NFW + 1)'(BRANCH_COUNT));
    assign alloc_val    = VALUE_BITS'(nf_reg);
    assign recip_prod   = PW'(rem_reg[VALUE_BITS-1:0]) * PW'(RECIP);
    assign qd_prod      = DW'(div_reg[VALUE_BITS-1:0]) * DW'(BRANCH_COUNT);
    assign rem_fix      = (rem_reg >= DW'(BRANCH_COUNT)) ? (rem_reg - DW'(BRANCH_COUNT))
                                                         : rem_reg;

    always_comb begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        nf_next         = nf_reg;
        branch_next     = branch_reg;
        level_next      = level_reg;
        key_next        = key_reg;
        mode_next       = mode_reg;
        wval_next       = wval_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        rd_branch       = branch_reg;
        rd_child        = child_cur;
        flags_we        = 1'b0;
        flags_waddr     = branch_reg;
        flags_wdata     = flags_q | (8'b1 << child_cur);
        slot_we         = 1'b0;
        slot_waddr      = {branch_reg, child_cur};
        slot_wdata      = wval_reg;
        q_pop           = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                flags_we    = 1'b1;
                flags_waddr = clr_cnt_reg[SAW-1:CHILD_W];
                flags_wdata = '0;
                slot_we     = 1'b1;
                slot_waddr  = clr_cnt_reg;
                slot_wdata  = '0;
                if (clr_cnt_reg == SAW'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_stat.valid) begin
                    q_pop       = 1'b1;
                    mode_next   = q_req.mode;
                    key_next    = q_req.key;
                    wval_next   = VALUE_BITS'(q_req.value);
                    level_next  = q_req.level;
                    branch_next = '0;
                    rd_branch   = '0;
                    rd_child    = child_of(q_req.key, q_req.level);
                    state_next  = ST_WALK;
                end
            end
            ST_ISSUE: begin
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (flag_hit) begin
                    if (ptr_in_range) begin
                        // Descend at once: drive the next read from the pointer.
                        branch_next = BIW'(slot_q);
                        level_next  = level_dn;
                        rd_branch   = BIW'(slot_q);
                        rd_child    = child_dn;
                    end else begin
                        rem_next   = DW'(slot_q);
                        step_next  = MOD_RECIP;
                        state_next = ST_MOD;
                    end
                end else if (mode_reg == MODE_READ) begin
                    res_value_next  = slot_q;
                    res_status_next = STATUS_DONE;
                    state_next      = ST_DONE;
                end else if (pool_short) begin
                    res_value_next  = '0;
                    res_status_next = STATUS_FULL;
                    state_next      = ST_DONE;
                end else if (level_reg == '0) begin
                    slot_we         = 1'b1;
                    res_value_next  = '0;
                    res_status_next = STATUS_DONE;
                    state_next      = ST_DONE;
                end else begin
                    state_next = ST_ALLOC;
                end
            end
            ST_MOD: begin
                // Reduce an out-of-range pointer: reciprocal estimate, subtract, correct once.
                step_next = step_reg - 1'b1;
                if (step_reg == MOD_RECIP) begin
                    div_next = DW'(recip_prod[PW-1:32]);
                end else if (step_reg == MOD_SUB) begin
                    rem_next = rem_reg - qd_prod;
                end else begin
                    branch_next = BIW'(rem_fix);
                    level_next  = level_dn;
                    state_next  = ST_ISSUE;
                end
            end
            ST_ALLOC: begin
                flags_we    = 1'b1;
                slot_we     = 1'b1;
                slot_wdata  = alloc_val;
                nf_next     = nf_reg + 1'b1;
                branch_next = BIW'(alloc_val);
                level_next  = level_dn;
                state_next  = (level_dn == '0) ? ST_LEAF : ST_AREAD;
            end
            ST_AREAD: begin
                state_next = ST_ALLOC;
            end
            ST_LEAF: begin
                slot_we         = 1'b1;
                res_value_next  = '0;
                res_status_next = STATUS_DONE;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            nf_reg        <= NFW'(1);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        branch_reg     <= branch_next;
        level_reg      <= level_next;
        key_reg        <= key_next;
        mode_reg       <= mode_next;
        wval_reg       <= wval_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        step_reg       <= step_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (flags_we) begin
            flags_mem[flags_waddr] <= flags_wdata;
        end
        flags_q <= flags_mem[rd_branch];
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[{rd_branch, rd_child}];
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_value_reg);
    assign m_tuser  = out_status_reg;

endmodule

/* src/sparse_octree_store.sv */
// Top level of the sparse octree store: front end, request queue and tree engine.
// A read walks from the root level down to the first missing child or the leaf; a write
// allocates each new branch in ST_ALLOC, with ST_AREAD in between, and stores the leaf slot
// in ST_LEAF; an out-of-range child pointer is reduced in ST_MOD. One request at a time.
// Reset: a clearing pass over all BRANCH_COUNT*8 slots (8192 by default) zeroes the memories;
// s_tready stays low meanwhile, cfg writes are taken throughout.
module sparse_octree_store #(
    parameter int BRANCH_COUNT = sos_pkg::BRANCH_COUNT_DEF,
    parameter int MAX_DEPTH    = sos_pkg::MAX_DEPTH_DEF,
    parameter int VALUE_BITS   = sos_pkg::VALUE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Depth register write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sos_pkg::CFG_W-1:0]       cfg_data,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sos_pkg::S_TDATA_W-1:0]   s_tdata,   // key[20:0], write_value[52:21]
    input  logic                            s_tuser,   // mode
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sos_pkg::M_TDATA_W-1:0]   m_tdata,   // read_value[31:0]
    output logic                            m_tuser    // status
);
    import sos_pkg::*;

    sos_qstat_t q_stat;
    sos_req_t   push_req;
    sos_req_t   head_req;
    logic       q_push;
    logic       q_pop;
    logic       clearing;

    // Accept requests and tag each with its root level.
    sos_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_stat    (q_stat),
        .clearing  (clearing),
        .q_push    (q_push),
        .q_req     (push_req)
    );

    // Hold requests so the front keeps taking input while the engine works.
    sos_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (push_req),
        .pop      (q_pop),
        .head_req (head_req),
        .stat     (q_stat)
    );

    // Walk, allocate and store; the result register parts the engine from m_tready.
    sos_back #(
        .BRANCH_COUNT (BRANCH_COUNT),
        .VALUE_BITS   (VALUE_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_req    (head_req),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // A refused write never carries a value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == STATUS_FULL)) |-> (m_tdata == '0))
        else $error("refused write carries nonzero read_value");

    // No request enters while the memories are being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_tready)
        else $error("request accepted during clearing pass");

    // No result can exist before the clearing pass ends.
    assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !m_tvalid)
        else $error("result presented during clearing pass");

    // The front never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full |-> !q_push)
        else $error("push into full request queue");

endmodule
